[sv/dpst_pkg.sv]
// Shared types, codes and score helpers for the depth-preferred search table.
package dpst_pkg;

	// Sizes
	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int MOVE_BITS_DEF     = 32;
	localparam int KEY_BITS          = 64;
	localparam int CMD_FIFO_DEPTH    = 2;
	localparam int RSP_FIFO_DEPTH    = 2;
	// Key folding for tables whose size is not a power of two
	localparam int REDUCE_BITS       = 4;
	localparam int REDUCE_STEPS      = KEY_BITS / REDUCE_BITS;

	localparam logic [14:0] MATE_THRESHOLD_RST = 15'd31000;

	// Operation codes on the input
	localparam logic [1:0] OP_PROBE = 2'd0;
	localparam logic [1:0] OP_STORE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Bound kinds on the input
	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_LOWER = 2'd1;
	localparam logic [1:0] BOUND_UPPER = 2'd2;

	// Slot kinds as kept in the table
	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_EXACT = 2'd1;
	localparam logic [1:0] KIND_LOWER = 2'd2;
	localparam logic [1:0] KIND_UPPER = 2'd3;

	// Command codes passed from front to back
	localparam logic [1:0] CMD_PROBE = 2'd0;
	localparam logic [1:0] CMD_STORE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic [63:0]        key;
		logic [6:0]         search_depth;
		logic signed [15:0] score;
		logic [1:0]         bound_kind;
		logic [31:0]        move_word;
		logic [6:0]         ply;
		logic signed [15:0] alpha_in;
		logic signed [15:0] beta_in;
	} request_t;

	typedef struct packed {
		logic               hit;
		logic [31:0]        move_out;
		logic signed [15:0] alpha_out;
		logic signed [15:0] beta_out;
		logic               eval_valid;
		logic signed [15:0] eval;
	} response_t;

	// Classified item; score already mate-adjusted for stores
	typedef struct packed {
		logic [1:0]         code;
		logic [63:0]        key;
		logic [6:0]         search_depth;
		logic [1:0]         kind;
		logic signed [15:0] score;
		logic [31:0]        move_word;
		logic [6:0]         ply;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [6:0]         depth;
		logic signed [15:0] score;
	} meta_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > 17'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -17'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Mate scores move away from zero by ply on store
	function automatic logic signed [15:0] adjust_in(input logic signed [15:0] s,
			input logic [6:0] ply, input logic [14:0] thr);
		logic signed [16:0] s17;
		logic signed [16:0] t17;
		logic signed [16:0] p17;
		logic signed [15:0] r;
		s17 = {s[15], s};
		t17 = $signed({2'b00, thr});
		p17 = $signed({10'd0, ply});
		if (s17 >= t17) begin
			r = sat16(s17 + p17);
		end else if (s17 <= -t17) begin
			r = sat16(s17 - p17);
		end else begin
			r = s;
		end
		return r;
	endfunction

	// And back toward zero on probe
	function automatic logic signed [15:0] adjust_out(input logic signed [15:0] s,
			input logic [6:0] ply, input logic [14:0] thr);
		logic signed [16:0] s17;
		logic signed [16:0] t17;
		logic signed [16:0] p17;
		logic signed [15:0] r;
		s17 = {s[15], s};
		t17 = $signed({2'b00, thr});
		p17 = $signed({10'd0, ply});
		if (s17 >= t17) begin
			r = sat16(s17 - p17);
		end else if (s17 <= -t17) begin
			r = sat16(s17 + p17);
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

[sv/dpst_fifo.sv]
// Small synchronous FIFO used for the command and result queues.
module dpst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[sv/dpst_front.sv]
// Front end: takes items, computes the slot index and classifies each item.
module dpst_front #(
	parameter int TABLE_ENTRIES = dpst_pkg::TABLE_ENTRIES_DEF,
	parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [14:0]            mate_threshold,
	input  logic                   push,
	input  dpst_pkg::request_t     request,
	output logic                   full,
	input  dpst_pkg::back_status_t status,
	output logic                   cmd_push,
	output dpst_pkg::cmd_t         cmd,
	output logic [IDX_W-1:0]       cmd_index,
	input  logic                   cmd_full
);
	import dpst_pkg::*;

	localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

	request_t cls_req;

	generate
		if (IS_POW2) begin : g_direct
			// Slot is the low key bits; items go straight into the queue
			assign cls_req   = request;
			assign full      = cmd_full | status.clearing;
			assign cmd_push  = push & ~full;
			assign cmd_index = request.key[IDX_W-1:0];
		end else begin : g_reduce
			localparam int STEP_W = $clog2(REDUCE_STEPS);

			request_t          req_q;
			logic              busy_q;
			logic              done_q;
			logic [STEP_W-1:0] step_q;
			logic [IDX_W-1:0]  rem_q;
			logic [63:0]       shift_q;
			logic [IDX_W-1:0]  rem_next;
			logic              accept;

			assign full      = busy_q | status.clearing;
			assign accept    = push & ~full;
			assign cmd_push  = busy_q & done_q & ~cmd_full;
			assign cls_req   = req_q;
			assign cmd_index = rem_q;

			// Key mod table size, a few key bits per cycle from the top
			always_comb begin
				logic [IDX_W:0] t;
				logic [IDX_W-1:0] r;
				r = rem_q;
				for (int i = 0; i < REDUCE_BITS; i++) begin
					t = {r, shift_q[63-i]};
					if (t >= (IDX_W+1)'(TABLE_ENTRIES)) begin
						t = t - (IDX_W+1)'(TABLE_ENTRIES);
					end
					r = t[IDX_W-1:0];
				end
				rem_next = r;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					step_q <= '0;
				end else begin
					if (accept) begin
						busy_q <= 1'b1;
						done_q <= 1'b0;
						step_q <= '0;
					end else if (busy_q && !done_q) begin
						step_q <= step_q + 1'b1;
						if (step_q == STEP_W'(REDUCE_STEPS - 1)) begin
							done_q <= 1'b1;
						end
					end else if (cmd_push) begin
						busy_q <= 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (accept) begin
					req_q   <= request;
					rem_q   <= '0;
					shift_q <= request.key;
				end else if (busy_q && !done_q) begin
					rem_q   <= rem_next;
					shift_q <= {shift_q[63-REDUCE_BITS:0], {REDUCE_BITS{1'b0}}};
				end
			end
		end
	endgenerate

	// Classify and pre-adjust the store score
	always_comb begin
		cmd.key          = cls_req.key;
		cmd.search_depth = cls_req.search_depth;
		cmd.score        = adjust_in(cls_req.score, cls_req.ply, mate_threshold);
		cmd.move_word    = cls_req.move_word;
		cmd.ply          = cls_req.ply;
		cmd.alpha        = cls_req.alpha_in;
		cmd.beta         = cls_req.beta_in;
		case (cls_req.bound_kind)
			BOUND_EXACT: cmd.kind = KIND_EXACT;
			BOUND_LOWER: cmd.kind = KIND_LOWER;
			BOUND_UPPER: cmd.kind = KIND_UPPER;
			default:     cmd.kind = KIND_EMPTY;
		endcase
		case (cls_req.operation)
			OP_PROBE: cmd.code = CMD_PROBE;
			OP_STORE: cmd.code = (cmd.kind == KIND_EMPTY) ? CMD_NOP : CMD_STORE;
			OP_CLEAR: cmd.code = CMD_CLEAR;
			default:  cmd.code = CMD_NOP;
		endcase
	end

endmodule

[sv/dpst_back.sv]
// Back end: table memory, probe/store read-modify-write and clearing sweep.
module dpst_back #(
	parameter int TABLE_ENTRIES = dpst_pkg::TABLE_ENTRIES_DEF,
	parameter int MOVE_BITS = dpst_pkg::MOVE_BITS_DEF,
	parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [14:0]            mate_threshold,
	input  logic                   cmd_empty,
	input  dpst_pkg::cmd_t         cmd,
	input  logic [IDX_W-1:0]       cmd_index,
	output logic                   cmd_pop,
	input  logic                   rsp_full,
	output logic                   rsp_push,
	output dpst_pkg::response_t    response,
	output dpst_pkg::back_status_t status
);
	import dpst_pkg::*;

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;
	localparam logic [1:0] ST_SWEEP = 2'd3;

	logic [63:0]          key_mem  [TABLE_ENTRIES];
	meta_t                meta_mem [TABLE_ENTRIES];
	logic [MOVE_BITS-1:0] move_mem [TABLE_ENTRIES];

	logic [1:0]           state_q;
	logic [IDX_W-1:0]     sweep_q;
	cmd_t                 cur_q;
	logic [IDX_W-1:0]     idx_q;
	logic [63:0]          rd_key_q;
	meta_t                rd_meta_q;
	logic [MOVE_BITS-1:0] rd_move_q;

	logic                 sweeping;
	logic                 sweep_last;
	logic                 store_wr;
	logic                 meta_we;
	logic [IDX_W-1:0]     wr_addr;
	meta_t                wr_meta;

	assign sweeping        = (state_q == ST_INIT) | (state_q == ST_SWEEP);
	assign sweep_last      = (sweep_q == IDX_W'(TABLE_ENTRIES - 1));
	assign status.clearing = sweeping;
	assign cmd_pop         = (state_q == ST_IDLE) & ~cmd_empty & ~rsp_full;
	assign rsp_push        = (state_q == ST_LOOK) | ((state_q == ST_SWEEP) & sweep_last);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
		end else begin
			case (state_q)
				ST_INIT, ST_SWEEP: begin
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						state_q <= (cmd.code == CMD_CLEAR) ? ST_SWEEP : ST_LOOK;
					end
				end
				ST_LOOK: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch the item and read its slot
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q     <= cmd;
			idx_q     <= cmd_index;
			rd_key_q  <= key_mem[cmd_index];
			rd_meta_q <= meta_mem[cmd_index];
			rd_move_q <= move_mem[cmd_index];
		end
	end

	// Depth-preferred replacement; an empty slot always takes the store
	assign store_wr = (state_q == ST_LOOK) & (cur_q.code == CMD_STORE)
		& ((rd_meta_q.kind == KIND_EMPTY) | (rd_key_q != cur_q.key)
		| (cur_q.search_depth >= rd_meta_q.depth));
	assign meta_we  = sweeping | store_wr;
	assign wr_addr  = sweeping ? sweep_q : idx_q;

	always_comb begin
		wr_meta.kind  = cur_q.kind;
		wr_meta.depth = cur_q.search_depth;
		wr_meta.score = cur_q.score;
		if (sweeping) begin
			wr_meta = '0;
		end
	end

	// Table writes
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[wr_addr] <= wr_meta;
		end
		if (store_wr) begin
			key_mem[idx_q]  <= cur_q.key;
			move_mem[idx_q] <= MOVE_BITS'(cur_q.move_word);
		end
	end

	// Probe evaluation
	always_comb begin
		logic               hit;
		logic signed [15:0] adj;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               valid;
		logic signed [15:0] ev;
		hit   = (state_q == ST_LOOK) & (cur_q.code == CMD_PROBE)
			& (rd_meta_q.kind != KIND_EMPTY) & (rd_key_q == cur_q.key);
		adj   = adjust_out(rd_meta_q.score, cur_q.ply, mate_threshold);
		a     = cur_q.alpha;
		b     = cur_q.beta;
		valid = 1'b0;
		ev    = '0;
		if (hit && (rd_meta_q.depth >= cur_q.search_depth)) begin
			if (rd_meta_q.kind == KIND_EXACT) begin
				valid = 1'b1;
				ev    = adj;
			end else if ((rd_meta_q.kind == KIND_LOWER) && (adj > a)) begin
				a = adj;
			end else if ((rd_meta_q.kind == KIND_UPPER) && (adj < b)) begin
				b = adj;
			end
			if (a >= b) begin
				valid = 1'b1;
				ev    = adj;
			end
		end
		response.hit        = hit;
		response.move_out   = hit ? 32'(rd_move_q) : 32'd0;
		response.alpha_out  = a;
		response.beta_out   = b;
		response.eval_valid = valid;
		response.eval       = ev;
	end

endmodule

[sv/depth_preferred_search_table_top.sv]
// Top level: front end, command queue, table back end and result queue.
// Probe/store/no-op: the back end reads the slot memory when it takes an item, then evaluates
// or writes in its look state, and takes the next item only after that one is through.
// Non-power-of-two sizes add key folding; the next item waits until the folded one is queued.
// Clear: one slot cleared per cycle over the whole table, then a result; full stays high.
// After reset the same clearing pass runs with full high.
module depth_preferred_search_table_top #(
	parameter int TABLE_ENTRIES = dpst_pkg::TABLE_ENTRIES_DEF,
	parameter int MOVE_BITS = dpst_pkg::MOVE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dpst_pkg::request_t  request,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output dpst_pkg::response_t response,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [14:0]         cfg_data
);
	import dpst_pkg::*;

	localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CMD_W   = $bits(cmd_t) + IDX_W;
	localparam int RSP_W   = $bits(response_t);

	logic [14:0]      mate_threshold_q;
	back_status_t     status;
	logic             f_push;
	cmd_t             f_cmd;
	logic [IDX_W-1:0] f_index;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic [CMD_W-1:0] q_rdata;
	cmd_t             q_cmd;
	logic [IDX_W-1:0] q_index;
	logic             r_push;
	logic             r_full;
	response_t        r_item;
	logic [RSP_W-1:0] r_rdata;

	// Mate threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_threshold_q <= MATE_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			mate_threshold_q <= cfg_data;
		end
	end

	dpst_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.mate_threshold(mate_threshold_q),
		.push(push),
		.request(request),
		.full(full),
		.status(status),
		.cmd_push(f_push),
		.cmd(f_cmd),
		.cmd_index(f_index),
		.cmd_full(q_full)
	);

	// Command queue between front and back
	dpst_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_FIFO_DEPTH)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_push),
		.wdata({f_index, f_cmd}),
		.full(q_full),
		.pop(q_pop),
		.empty(q_empty),
		.rdata(q_rdata)
	);

	assign {q_index, q_cmd} = q_rdata;

	dpst_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MOVE_BITS(MOVE_BITS),
		.IDX_W(IDX_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mate_threshold(mate_threshold_q),
		.cmd_empty(q_empty),
		.cmd(q_cmd),
		.cmd_index(q_index),
		.cmd_pop(q_pop),
		.rsp_full(r_full),
		.rsp_push(r_push),
		.response(r_item),
		.status(status)
	);

	// Result queue
	dpst_fifo #(
		.WIDTH(RSP_W),
		.DEPTH(RSP_FIFO_DEPTH)
	) u_rsp_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(r_push),
		.wdata(r_item),
		.full(r_full),
		.pop(pop),
		.empty(empty),
		.rdata(r_rdata)
	);

	assign response = r_rdata;

endmodule

[verif/search_table_checker.sv]
`timescale 1ns / 100ps
// Checker for the search table: predicts each response and compares it with the block.
module search_table_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dpst_pkg::request_t  request,
	input  logic                full,
	input  logic                pop,
	input  logic                empty,
	input  dpst_pkg::response_t response,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [14:0]         cfg_data,
	output int                  failures,
	output int                  outstanding
);
	import dpst_pkg::*;

	localparam int SLOTS = TABLE_ENTRIES_DEF;

	// Shadow copy of the table and the threshold register
	logic [63:0] slot_keys  [SLOTS];
	meta_t       slot_info  [SLOTS];
	logic [31:0] slot_moves [SLOTS];
	logic [14:0] mate_thr;

	response_t expected_responses[$];
	int        mismatches = 0;

	function automatic void wipe_table();
		for (int i = 0; i < SLOTS; i++) begin
			slot_keys[i]  = '0;
			slot_info[i]  = '0;
			slot_moves[i] = '0;
		end
	endfunction

	// Mate scores shift by step away from zero, then saturate to 16 bits
	function automatic logic signed [15:0] mate_shift(input logic signed [15:0] s,
			input int step);
		int v;
		int t;
		v = s;
		t = mate_thr;
		if (v >= t) begin
			v = v + step;
		end else if (v <= -t) begin
			v = v - step;
		end
		if (v > 32767) begin
			v = 32767;
		end else if (v < -32768) begin
			v = -32768;
		end
		return 16'(v);
	endfunction

	// One item through the table: updates the shadow state, returns the response
	function automatic response_t table_model_step(input request_t rq);
		response_t           rs;
		int                  slot;
		meta_t               m;
		logic signed [15:0]  adj;
		slot = int'(rq.key % SLOTS);
		rs = '0;
		rs.alpha_out = rq.alpha_in;
		rs.beta_out  = rq.beta_in;
		case (rq.operation)
			OP_CLEAR: begin
				wipe_table();
			end
			OP_STORE: begin
				// depth-preferred replacement; bound kind 3 is dropped
				if (rq.bound_kind <= BOUND_UPPER &&
						(slot_keys[slot] != rq.key ||
						rq.search_depth >= slot_info[slot].depth)) begin
					slot_keys[slot]        = rq.key;
					slot_info[slot].kind   = rq.bound_kind + 2'd1;  // exact/lower/upper
					slot_info[slot].depth  = rq.search_depth;
					slot_info[slot].score  = mate_shift(rq.score, int'(rq.ply));
					slot_moves[slot]       = rq.move_word;
				end
			end
			OP_PROBE: begin
				m = slot_info[slot];
				if (m.kind != KIND_EMPTY && slot_keys[slot] == rq.key) begin
					rs.hit      = 1'b1;
					rs.move_out = slot_moves[slot];
					if (m.depth >= rq.search_depth) begin
						adj = mate_shift(m.score, -int'(rq.ply));
						if (m.kind == KIND_EXACT) begin
							rs.eval_valid = 1'b1;
						end else if (m.kind == KIND_LOWER && adj > rs.alpha_out) begin
							rs.alpha_out = adj;
						end else if (m.kind == KIND_UPPER && adj < rs.beta_out) begin
							rs.beta_out = adj;
						end
						if (rs.alpha_out >= rs.beta_out) begin
							rs.eval_valid = 1'b1;
						end
						if (rs.eval_valid) begin
							rs.eval = adj;
						end
					end
				end
			end
			default: ;  // unused code answers like a store, changes nothing
		endcase
		return rs;
	endfunction

	// Watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_table();
			mate_thr = MATE_THRESHOLD_RST;
			expected_responses.delete();
			failures    <= 0;
			outstanding <= 0;
		end else begin
			response_t want;
			if (cfg_valid && cfg_ready) begin
				mate_thr = cfg_data;
			end
			// compare the accepted response against the oldest prediction
			if (pop && !empty) begin
				if (expected_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: response with nothing expected: hit=%0b move=%h",
							$realtime, response.hit, response.move_out);
					end
				end else begin
					want = expected_responses.pop_front();
					if (response.hit !== want.hit || response.move_out !== want.move_out ||
							response.alpha_out !== want.alpha_out ||
							response.beta_out !== want.beta_out ||
							response.eval_valid !== want.eval_valid ||
							response.eval !== want.eval) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch exp hit=%0b move=%h a=%0d b=%0d v=%0b e=%0d",
								$realtime, want.hit, want.move_out, want.alpha_out,
								want.beta_out, want.eval_valid, want.eval);
							$display("%0t:          got hit=%0b move=%h a=%0d b=%0d v=%0b e=%0d",
								$realtime, response.hit, response.move_out,
								response.alpha_out, response.beta_out,
								response.eval_valid, response.eval);
						end
					end
				end
			end
			if (push && !full) begin
				expected_responses.push_back(table_model_step(request));
			end
			failures    <= mismatches;
			outstanding <= expected_responses.size();
		end
	end

endmodule

[verif/depth_preferred_search_table_top_test.sv]
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus and verdict for the search table.
module depth_preferred_search_table_top_test;
	import dpst_pkg::*;

	// Input codes with no package name
	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam logic [1:0] BOUND_INVALID = 2'd3;
	localparam int         PHASE_ITEMS   = 85;
	localparam int         PHASES        = 5;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	request_t    request   = '0;
	logic        full;
	logic        pop       = 1'b0;
	logic        empty;
	response_t   response;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [14:0] cfg_data  = MATE_THRESHOLD_RST;

	int   failures;
	int   outstanding;
	logic no_idle       = 1'b0;
	logic long_hold_req = 1'b0;

	logic [63:0] key_pool [16];

	depth_preferred_search_table_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.request   (request),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.response  (response),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	search_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.request     (request),
		.full        (full),
		.pop         (pop),
		.empty       (empty),
		.response    (response),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic request_t make_req(input logic [1:0] op, input logic [63:0] key,
			input int depth, input int score, input logic [1:0] bound,
			input logic [31:0] move, input int ply, input int alpha, input int beta);
		request_t r;
		r.operation    = op;
		r.key          = key;
		r.search_depth = 7'(depth);
		r.score        = 16'(score);
		r.bound_kind   = bound;
		r.move_word    = move;
		r.ply          = 7'(ply);
		r.alpha_in     = 16'(alpha);
		r.beta_in      = 16'(beta);
		return r;
	endfunction

	function automatic int clamp16(input int v);
		if (v > 32767) begin
			return 32767;
		end else if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	// Random item: mostly stores and probes on a small key pool with colliding pairs
	function automatic request_t random_item(input logic [14:0] thr);
		request_t r;
		int       sel;
		int       s;
		int       a;
		int       b;
		sel = $urandom_range(0, 99);
		if (sel < 46) begin
			r.operation = OP_STORE;
		end else if (sel < 95) begin
			r.operation = OP_PROBE;
		end else if (sel < 98) begin
			r.operation = OP_UNUSED;
		end else begin
			r.operation = OP_CLEAR;
		end
		r.key = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom}
			: key_pool[$urandom_range(0, 15)];
		r.search_depth = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
			: 7'($urandom_range(0, 12));
		case ($urandom_range(0, 4))
			0: s = int'(thr) + int'($urandom_range(0, 8)) - 4;
			1: s = -int'(thr) + int'($urandom_range(0, 8)) - 4;
			2: s = $urandom_range(0, 1) ? 32767 : -32768;
			3: s = int'($urandom_range(0, 4000)) - 2000;
			default: s = int'($signed(16'($urandom)));
		endcase
		r.score      = 16'(clamp16(s));
		r.bound_kind = ($urandom_range(0, 9) == 0) ? BOUND_INVALID
			: 2'($urandom_range(0, 2));
		r.move_word  = $urandom;
		r.ply        = 7'($urandom_range(0, 127));
		if ($urandom_range(0, 3) == 0) begin
			a = int'($signed(16'($urandom)));
			b = int'($signed(16'($urandom)));
		end else begin
			a = ($urandom_range(0, 1) ? int'(thr) : 0) + int'($urandom_range(0, 4000)) - 2000;
			b = a + int'($urandom_range(0, 3000)) - 500;
		end
		r.alpha_in = 16'(clamp16(a));
		r.beta_in  = 16'(clamp16(b));
		return r;
	endfunction

	// Offer one item, with an occasional idle burst ahead of it
	task automatic send_item(input request_t r);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		push    <= 1'b1;
		request <= r;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// Stop offering, then wait until every accepted item has its result back
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [14:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: random stall bursts, plus one long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = 80;
				pop <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 10) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		logic [63:0] k1;
		logic [63:0] k2;
		logic [63:0] k3;
		logic [63:0] k4;
		logic [14:0] thr;
		k1 = {$urandom, $urandom};
		k2 = {~k1[63:10], k1[9:0]};
		k3 = {$urandom, $urandom};
		k4 = {$urandom, $urandom};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty slot whose stored key is zero must still miss
		send_item(make_req(OP_PROBE, '0, 0, 0, BOUND_EXACT, '0, 0, -32768, 32767));
		send_item(make_req(OP_PROBE, k1, 0, 0, BOUND_EXACT, '0, 0, -32768, 32767));
		send_item(make_req(OP_STORE, '0, 0, 0, BOUND_EXACT, '0, 0, 0, 0));
		send_item(make_req(OP_PROBE, '0, 0, 0, BOUND_EXACT, '0, 0, -32768, 32767));
		// top extremes: mate score saturates on store
		send_item(make_req(OP_STORE, '1, 127, 32767, BOUND_EXACT, '1, 127, 32767, -32768));
		send_item(make_req(OP_PROBE, '1, 127, 0, BOUND_EXACT, '0, 127, -32768, 32767));
		send_item(make_req(OP_STORE, k1, 10, -32768, BOUND_LOWER, 32'h1234_5678, 5, 0, 0));
		send_item(make_req(OP_PROBE, k1, 5, 0, BOUND_EXACT, '0, 0, -100, 100));
		// shallower store to the same key is rejected
		send_item(make_req(OP_STORE, k1, 9, 500, BOUND_EXACT, 32'hdead_beef, 0, 0, 0));
		send_item(make_req(OP_PROBE, k1, 10, 0, BOUND_EXACT, '0, 0, -100, 100));
		// equal depth replaces; lower bound raises alpha, then closes the window
		send_item(make_req(OP_STORE, k1, 10, 31000, BOUND_LOWER, 32'h0bad_cafe, 3, 0, 0));
		send_item(make_req(OP_PROBE, k1, 10, 0, BOUND_EXACT, '0, 3, 0, 32767));
		send_item(make_req(OP_PROBE, k1, 10, 0, BOUND_EXACT, '0, 3, 0, 31000));
		// colliding key evicts regardless of depth
		send_item(make_req(OP_STORE, k2, 0, -31000, BOUND_UPPER, 32'h5555_aaaa, 7, 0, 0));
		send_item(make_req(OP_PROBE, k1, 0, 0, BOUND_EXACT, '0, 0, -100, 100));
		send_item(make_req(OP_PROBE, k2, 0, 0, BOUND_EXACT, '0, 7, -50, 50));
		// shallow hit: move only
		send_item(make_req(OP_PROBE, k2, 1, 0, BOUND_EXACT, '0, 7, -50, 50));
		// window already closed on entry
		send_item(make_req(OP_STORE, k3, 5, 0, BOUND_LOWER, 32'h0000_0001, 0, 0, 0));
		send_item(make_req(OP_PROBE, k3, 5, 0, BOUND_EXACT, '0, 0, 10, -10));
		// invalid bound kind and unused operation change nothing
		send_item(make_req(OP_STORE, k4, 3, 77, BOUND_INVALID, 32'h8000_0000, 1, 0, 0));
		send_item(make_req(OP_PROBE, k4, 0, 0, BOUND_EXACT, '0, 0, -10, 10));
		send_item(make_req(OP_UNUSED, k3, 127, -1, BOUND_EXACT, '1, 127, 12, 34));
		send_item(make_req(OP_CLEAR, '0, 0, 0, BOUND_EXACT, '0, 0, -5, 5));
		send_item(make_req(OP_PROBE, '1, 0, 0, BOUND_EXACT, '0, 0, -32768, 32767));

		// Random phases, one threshold setting each
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: thr = 15'd32767;
				1: thr = 15'd0;
				2: thr = 15'd100;
				3: thr = MATE_THRESHOLD_RST;
				default: thr = 15'($urandom_range(1, 32766));
			endcase
			wait_drained();
			write_threshold(thr);
			for (int i = 0; i < 16; i += 2) begin
				key_pool[i]     = {$urandom, $urandom};
				key_pool[i + 1] = {$urandom, $urandom};
				key_pool[i + 1][9:0] = key_pool[i][9:0];
			end
			no_idle = (ph == PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 20) begin
					long_hold_req = 1'b1;
				end
				send_item(random_item(thr));
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
